/* hw/rtl/i2cmbe_pkg.sv */
// Shared types, codes and slot tables of the I2C master byte engine.
// Used by every module of the block; depends on nothing.
`default_nettype none

package i2cmbe_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int PHASE_W       = 8;
    localparam int IDX_W         = 5;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QCNT_W        = 2;
    localparam logic [PHASE_W-1:0] PHASE_RESET = 8'd4;

    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_IDLE     = 3'd1,
        OP_START    = 3'd2,
        OP_STOP     = 3'd3,
        OP_WRITE    = 3'd4,
        OP_READ     = 3'd5,
        OP_WAIT_ACK = 3'd6
    } t_op;

    localparam logic [2:0] OP_CODE_MAX = OP_WAIT_ACK;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_missing;
    } t_out_item;

    // Item after classification by the front part
    typedef struct packed {
        logic       is_cmd;
        t_op        op;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } t_cls_item;

    // Number of bus slots in a command
    function automatic logic [IDX_W-1:0] slot_total(input t_op cmd);
        logic [IDX_W-1:0] total;
        unique case (cmd)
            OP_NONE:     total = IDX_W'(0);
            OP_IDLE:     total = IDX_W'(1);
            OP_START:    total = IDX_W'(3);
            OP_STOP:     total = IDX_W'(1);
            OP_WRITE:    total = IDX_W'(3 * BITS_PER_BYTE);
            OP_READ:     total = IDX_W'(2 * BITS_PER_BYTE + 3);
            OP_WAIT_ACK: total = IDX_W'(3);
        endcase
        return total;
    endfunction

    // Line levels on entry to a slot; returns {scl, sda}
    function automatic logic [1:0] slot_levels(
        input t_op              cmd,
        input logic [IDX_W-1:0] idx,
        input logic [7:0]       shift,
        input logic             ack,
        input logic             scl_in,
        input logic             sda_in
    );
        logic [8:0]       prod;
        logic [2:0]       bit_no;
        logic [IDX_W-1:0] phase_no;
        logic             scl;
        logic             sda;
        scl      = scl_in;
        sda      = sda_in;
        // idx / 3 by reciprocal, exact for idx below 24 (bit_no is three bits wide)
        prod     = {4'b0, idx} * 9'd11;
        bit_no   = prod[7:5];
        phase_no = idx - IDX_W'({2'b0, bit_no} * 5'd3);
        unique case (cmd)
            OP_NONE: begin
            end
            OP_IDLE: begin
                sda = 1'b1;
                scl = 1'b1;
            end
            OP_START: begin
                if (idx == IDX_W'(0)) begin
                    sda = 1'b1;
                    scl = 1'b1;
                end else if (idx == IDX_W'(1)) begin
                    sda = 1'b0;
                end else begin
                    scl = 1'b0;
                end
            end
            OP_STOP: begin
                sda = 1'b0;
                scl = 1'b1;
            end
            OP_WRITE: begin
                if (phase_no == IDX_W'(0)) begin
                    sda = shift[3'(BITS_PER_BYTE - 1) - bit_no];
                end else if (phase_no == IDX_W'(1)) begin
                    scl = 1'b1;
                end else begin
                    scl = 1'b0;
                    if (bit_no == 3'(BITS_PER_BYTE - 1)) begin
                        sda = 1'b1;
                    end
                end
            end
            OP_READ: begin
                if (idx < IDX_W'(2 * BITS_PER_BYTE)) begin
                    if (!idx[0]) begin
                        if (idx == IDX_W'(0)) begin
                            sda = 1'b1;
                        end
                        scl = 1'b1;
                    end else begin
                        scl = 1'b0;
                    end
                end else if (idx == IDX_W'(2 * BITS_PER_BYTE)) begin
                    sda = ~ack;
                end else if (idx == IDX_W'(2 * BITS_PER_BYTE + 1)) begin
                    scl = 1'b1;
                end else begin
                    scl = 1'b0;
                end
            end
            OP_WAIT_ACK: begin
                if (idx == IDX_W'(0)) begin
                    sda = 1'b1;
                end else if (idx == IDX_W'(1)) begin
                    scl = 1'b1;
                end else begin
                    scl = 1'b0;
                end
            end
        endcase
        return {scl, sda};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/i2cmbe_front.sv */
// Front part: accepts tick items, classifies the op code and queues them.
// Depends on i2cmbe_pkg.
`default_nettype none

module i2cmbe_front import i2cmbe_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire t_in_item  i_in_item,
    output logic           o_avail,
    input  wire logic      i_take,
    output t_cls_item      o_item
);

    t_cls_item         r_mem [QUEUE_DEPTH];
    logic              r_wr_ptr, n_wr_ptr;
    logic              r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    t_cls_item         cls;
    logic              do_push;
    logic              do_take;

    // Codes zero and seven carry no command
    always_comb begin
        cls.is_cmd     = (i_in_item.op != 3'(OP_NONE)) && (i_in_item.op <= OP_CODE_MAX);
        cls.op         = cls.is_cmd ? t_op'(i_in_item.op) : OP_NONE;
        cls.write_data = i_in_item.write_data;
        cls.send_ack   = i_in_item.send_ack;
        cls.sda_in     = i_in_item.sda_in;
    end

    assign full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = push && !full;
    assign do_take = i_take && o_avail;

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_take ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + QCNT_W'(do_push) - QCNT_W'(do_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= cls;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("front queue count out of range");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCNT_W'(QUEUE_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("front queue pointers disagree with count");

    a_take_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_take && !do_push) |=> (r_count == $past(r_count) - QCNT_W'(1)))
        else $error("front queue take lost");

endmodule

`default_nettype wire

/* hw/rtl/i2cmbe_seq.sv */
// Back part: bus slot sequencer, one tick item per cycle while an item is available and the result queue has room.
// Depends on i2cmbe_pkg.
`default_nettype none

module i2cmbe_seq import i2cmbe_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic [7:0]   i_phase_ticks,
    input  wire logic         i_avail,
    output logic              o_take,
    input  wire t_cls_item    i_item,
    output logic              empty,
    input  wire logic         pop,
    output t_out_item         o_out_item
);

    // Sequencer state
    t_op              r_cmd,   n_cmd;
    logic [7:0]       r_cnt,   n_cnt;
    logic [IDX_W-1:0] r_idx,   n_idx;
    logic [7:0]       r_shift, n_shift;
    logic             r_ack,   n_ack;
    logic             r_scl,   n_scl;
    logic             r_sda,   n_sda;
    logic             r_nack,  n_nack;
    logic [7:0]       r_hold,  n_hold;

    // Result queue
    t_out_item         r_mem [QUEUE_DEPTH];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    t_out_item        res;
    logic [8:0]       phase;
    logic [IDX_W:0]   idx_next;
    logic             fire;
    logic             do_pop;
    logic             q_full;

    assign q_full = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign fire   = i_avail && !q_full;
    assign o_take = fire;
    assign empty  = (r_count == '0);
    assign do_pop = pop && !empty;
    assign o_out_item = r_mem[r_rd_ptr];

    always_comb begin
        n_cmd   = r_cmd;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_shift = r_shift;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_nack  = r_nack;
        n_hold  = r_hold;
        res     = '0;
        phase   = (i_phase_ticks == '0) ? 9'd1 : {1'b0, i_phase_ticks};
        idx_next = '0;

        // Commands are only taken while idle
        if (r_cmd == OP_NONE && i_item.is_cmd) begin
            n_cmd = i_item.op;
            n_idx = '0;
            n_cnt = '0;
            if (i_item.op == OP_WRITE) begin
                n_shift = i_item.write_data;
            end
            if (i_item.op == OP_READ) begin
                n_shift = '0;
                n_ack   = i_item.send_ack;
            end
            {n_scl, n_sda} = slot_levels(n_cmd, n_idx, n_shift, n_ack, n_scl, n_sda);
        end

        res.scl_out = n_scl;
        res.sda_out = n_sda;

        if (n_cmd != OP_NONE) begin
            res.busy_res = 1'b1;
            if ({1'b0, n_cnt} + 9'd1 >= phase) begin
                // Sample at the end of SCL-high slots
                if (n_cmd == OP_READ && n_idx < IDX_W'(2 * BITS_PER_BYTE) && !n_idx[0]) begin
                    n_shift = {n_shift[6:0], i_item.sda_in};
                end
                if (n_cmd == OP_WAIT_ACK && n_idx == IDX_W'(1)) begin
                    n_nack = i_item.sda_in;
                end
                n_cnt    = '0;
                idx_next = {1'b0, n_idx} + (IDX_W + 1)'(1);
                n_idx    = idx_next[IDX_W-1:0];
                if (idx_next >= {1'b0, slot_total(n_cmd)}) begin
                    res.done_res = 1'b1;
                    if (n_cmd == OP_STOP) begin
                        n_sda = 1'b1;
                    end
                    if (n_cmd == OP_READ) begin
                        n_hold = n_shift;
                        if (n_ack) begin
                            n_sda = 1'b1;
                        end
                    end
                    n_cmd = OP_NONE;
                    n_idx = '0;
                end else begin
                    {n_scl, n_sda} = slot_levels(n_cmd, n_idx, n_shift, n_ack, n_scl, n_sda);
                end
            end else begin
                n_cnt = n_cnt + 8'd1;
            end
        end

        res.read_byte   = n_hold;
        res.ack_missing = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= OP_NONE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_shift <= '0;
            r_ack   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_nack  <= 1'b0;
            r_hold  <= '0;
        end else if (fire) begin
            r_cmd   <= n_cmd;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_shift <= n_shift;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_nack  <= n_nack;
            r_hold  <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (fire) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + QCNT_W'(fire) - QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_mem[r_wr_ptr] <= res;
        end
    end

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd == OP_NONE) |-> (r_cnt == '0 && r_idx == '0))
        else $error("idle sequencer holds slot position");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd != OP_NONE) |-> (r_idx < slot_total(r_cmd)))
        else $error("slot index past end of command");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res.done_res) |-> (res.busy_res && n_cmd == OP_NONE))
        else $error("done without ending the command");

    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue count out of range");

endmodule

`default_nettype wire

/* hw/rtl/i2c_master_byte_engine_unit.sv */
// I2C master byte engine top level: slot-time register and the two parts.
// Depends on i2cmbe_pkg, i2cmbe_front and i2cmbe_seq.
//
// Each input item is one base time tick; every item gives exactly one result,
// and one item is taken per clock cycle as long as results are popped. A tick's
// result is written to the result queue when the sequencer takes it from the
// front queue, and can be popped from there. The rate is set by the slot
// sequencer, which advances one tick per cycle while its result queue has room; a
// two-entry queue on each side lets push and pop stall independently. Commands
// arriving while a command is running are dropped. The slot length register
// (phase_ticks, zero acts as one) is always ready and must be written only
// while no ticks are in flight.
`default_nettype none

module i2c_master_byte_engine_unit import i2cmbe_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire t_in_item   i_in_item,
    output logic            empty,
    input  wire logic       pop,
    output t_out_item       o_out_item,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    logic [PHASE_W-1:0] r_phase_ticks;
    logic               avail;
    logic               take;
    t_cls_item          cls_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_phase_ticks <= i_cfg_data;
        end
    end

    i2cmbe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .o_avail   (avail),
        .i_take    (take),
        .o_item    (cls_item)
    );

    i2cmbe_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_ticks (r_phase_ticks),
        .i_avail       (avail),
        .o_take        (take),
        .i_item        (cls_item),
        .empty         (empty),
        .pop           (pop),
        .o_out_item    (o_out_item)
    );

endmodule

`default_nettype wire

/* dv/i2cmbe_line_checker.sv */
`timescale 1ns / 100ps
// Line checker for the I2C master byte engine: watches the tick, result and
// slot-length channels, predicts every result and compares it field by field.
// Depends on i2cmbe_pkg.

module i2cmbe_line_checker import i2cmbe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  t_in_item   i_in_item,
    input  logic       i_empty,
    input  logic       i_pop,
    input  t_out_item  i_out_item,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_results_due
);

    t_op        cur_cmd;
    logic [7:0] slot_ticks;
    logic [4:0] slot_no;
    logic [7:0] shifter;
    logic       ack_sel;
    logic       scl_q;
    logic       sda_q;
    logic       nack_q;
    logic [7:0] rx_byte;
    logic [7:0] phase_reg;
    t_out_item  line_results_due[$];
    t_out_item  predicted;
    t_out_item  oldest;
    int         result_no;

    initial begin
        o_fail_count  = 0;
        o_results_due = 0;
    end

    function automatic int cmd_slots(input t_op cmd);
        case (cmd)
            OP_IDLE, OP_STOP:      return 1;
            OP_START, OP_WAIT_ACK: return 3;
            OP_WRITE:              return 3 * BITS_PER_BYTE;
            OP_READ:               return 2 * BITS_PER_BYTE + 3;
            default:               return 0;
        endcase
    endfunction

    // Set the line levels that a slot opens with
    task automatic enter_slot_levels();
        int unsigned bit_no;
        int unsigned step;
        bit_no = slot_no / 3;
        step   = slot_no % 3;
        case (cur_cmd)
            OP_IDLE: begin
                sda_q = 1'b1;
                scl_q = 1'b1;
            end
            OP_START: begin
                if (slot_no == 5'd0) begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                end else if (slot_no == 5'd1) begin
                    sda_q = 1'b0;
                end else begin
                    scl_q = 1'b0;
                end
            end
            OP_STOP: begin
                sda_q = 1'b0;
                scl_q = 1'b1;
            end
            OP_WRITE: begin
                if (step == 0) begin
                    sda_q = shifter[BITS_PER_BYTE - 1 - bit_no];
                end else if (step == 1) begin
                    scl_q = 1'b1;
                end else begin
                    scl_q = 1'b0;
                    // release the data line after the last bit
                    if (bit_no == BITS_PER_BYTE - 1) sda_q = 1'b1;
                end
            end
            OP_READ: begin
                if (slot_no < 2 * BITS_PER_BYTE) begin
                    if (slot_no % 2 == 0) begin
                        if (slot_no == 5'd0) sda_q = 1'b1;
                        scl_q = 1'b1;
                    end else begin
                        scl_q = 1'b0;
                    end
                end else if (slot_no == 2 * BITS_PER_BYTE) begin
                    sda_q = ~ack_sel;
                end else if (slot_no == 2 * BITS_PER_BYTE + 1) begin
                    scl_q = 1'b1;
                end else begin
                    scl_q = 1'b0;
                end
            end
            OP_WAIT_ACK: begin
                if (slot_no == 5'd0) begin
                    sda_q = 1'b1;
                end else if (slot_no == 5'd1) begin
                    scl_q = 1'b1;
                end else begin
                    scl_q = 1'b0;
                end
            end
            default: begin
            end
        endcase
    endtask

    // One base tick of the bus sequencer
    task automatic advance_bus_tick(input t_in_item it, output t_out_item res);
        int unsigned eff_phase;
        int unsigned idx;
        eff_phase = (phase_reg == 8'd0) ? 1 : phase_reg;
        res = '0;
        // commands are taken only while the sequencer is idle
        if (cur_cmd == OP_NONE && it.op >= OP_IDLE && it.op <= OP_WAIT_ACK) begin
            cur_cmd    = t_op'(it.op);
            slot_no    = '0;
            slot_ticks = '0;
            if (cur_cmd == OP_WRITE) shifter = it.write_data;
            if (cur_cmd == OP_READ) begin
                shifter = '0;
                ack_sel = it.send_ack;
            end
            enter_slot_levels();
        end
        res.scl_out = scl_q;
        res.sda_out = sda_q;
        if (cur_cmd != OP_NONE) begin
            res.busy_res = 1'b1;
            if (slot_ticks + 1 >= eff_phase) begin
                idx = slot_no;
                if (cur_cmd == OP_READ && idx < 2 * BITS_PER_BYTE && idx % 2 == 0) begin
                    shifter = {shifter[6:0], it.sda_in};
                end
                if (cur_cmd == OP_WAIT_ACK && idx == 1) nack_q = it.sda_in;
                slot_ticks = '0;
                slot_no    = 5'(idx + 1);
                if (idx + 1 >= cmd_slots(cur_cmd)) begin
                    res.done_res = 1'b1;
                    // level changes at the end show from the next tick
                    if (cur_cmd == OP_STOP) sda_q = 1'b1;
                    if (cur_cmd == OP_READ) begin
                        rx_byte = shifter;
                        if (ack_sel) sda_q = 1'b1;
                    end
                    cur_cmd = OP_NONE;
                    slot_no = '0;
                end else begin
                    enter_slot_levels();
                end
            end else begin
                slot_ticks = slot_ticks + 8'd1;
            end
        end
        res.read_byte   = rx_byte;
        res.ack_missing = nack_q;
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            if (o_fail_count < 10) begin
                $display("result %0d: %s expected %0h, got %0h", result_no, field, want, got);
            end
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_cmd    = OP_NONE;
            slot_ticks = '0;
            slot_no    = '0;
            shifter    = '0;
            ack_sel    = 1'b0;
            scl_q      = 1'b1;
            sda_q      = 1'b1;
            nack_q     = 1'b0;
            rx_byte    = '0;
            phase_reg  = PHASE_RESET;
            result_no  = 0;
            line_results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) phase_reg = i_cfg_data;
            if (i_push && !i_full) begin
                advance_bus_tick(i_in_item, predicted);
                line_results_due.push_back(predicted);
            end
            if (i_pop && !i_empty) begin
                if (line_results_due.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("result %0d: arrived with nothing predicted", result_no);
                    end
                    o_fail_count++;
                end else begin
                    oldest = line_results_due.pop_front();
                    check_field("scl_out", oldest.scl_out, i_out_item.scl_out);
                    check_field("sda_out", oldest.sda_out, i_out_item.sda_out);
                    check_field("busy_res", oldest.busy_res, i_out_item.busy_res);
                    check_field("done_res", oldest.done_res, i_out_item.done_res);
                    check_field("read_byte", oldest.read_byte, i_out_item.read_byte);
                    check_field("ack_missing", oldest.ack_missing, i_out_item.ack_missing);
                end
                result_no++;
            end
        end
        o_results_due = line_results_due.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Top of the I2C master byte engine testbench: clock, reset, tick and
// slot-length stimulus, result draining and the verdict.
// Depends on i2cmbe_pkg, i2c_master_byte_engine_unit and i2cmbe_line_checker.

module testbench;
    import i2cmbe_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [2:0] OP_UNUSED   = 3'd7;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       push      = 1'b0;
    logic       pop       = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = 8'd0;
    t_in_item   in_item   = '0;
    logic       full;
    logic       empty;
    logic       cfg_ready;
    t_out_item  out_item;
    int         fail_count;
    int         results_due;

    int         push_idle_pct = 0;
    int         pop_idle_pct  = 0;
    logic [7:0] cur_phase     = PHASE_RESET;
    int         ticks_left    = 0;
    t_op        plan[$];

    i2c_master_byte_engine_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    i2cmbe_line_checker u_line_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_in_item     (in_item),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_out_item    (out_item),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: pop, with random stall bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (pop_idle_pct != 0 && $urandom_range(1, 100) <= pop_idle_pct) begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Ticks a command keeps the bus busy after the tick that carries it
    function automatic int busy_ticks(input logic [2:0] op);
        int slots;
        int eff;
        eff = (cur_phase == 8'd0) ? 1 : cur_phase;
        case (op)
            OP_IDLE, OP_STOP:      slots = 1;
            OP_START, OP_WAIT_ACK: slots = 3;
            OP_WRITE:              slots = 3 * BITS_PER_BYTE;
            OP_READ:               slots = 2 * BITS_PER_BYTE + 3;
            default:               slots = 0;
        endcase
        return (slots == 0) ? 0 : slots * eff - 1;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_tick(input t_in_item it);
        if (push_idle_pct != 0 && $urandom_range(1, 100) <= push_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        push    <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic send_op(input logic [2:0] op, input logic [7:0] data,
                           input logic ack, input logic sda);
        t_in_item it;
        it.op         = op;
        it.write_data = data;
        it.send_ack   = ack;
        it.sda_in     = sda;
        send_tick(it);
    endtask

    // Issue a command and hold the bus ticking until it finishes
    task automatic run_cmd(input t_op op, input logic [7:0] data,
                           input logic ack, input logic sda);
        send_op(op, data, ack, sda);
        repeat (busy_ticks(op)) send_op(OP_NONE, data, ack, sda);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (results_due != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_phase(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        cur_phase = value;
        repeat (2) @(negedge i_clk);
    endtask

    // Next tick: mostly well-formed transactions, with stray and dropped commands
    task automatic make_tick(output t_in_item it);
        it.op         = OP_NONE;
        it.write_data = 8'($urandom);
        it.send_ack   = 1'($urandom);
        it.sda_in     = 1'($urandom);
        if (ticks_left > 0) begin
            ticks_left--;
            // commands while busy must be dropped
            if ($urandom_range(0, 19) == 0) it.op = 3'($urandom_range(0, 7));
        end else if (plan.size() != 0) begin
            if ($urandom_range(0, 5) != 0) begin
                it.op      = plan.pop_front();
                ticks_left = busy_ticks(it.op);
            end
        end else if ($urandom_range(0, 9) < 2) begin
            it.op      = 3'($urandom_range(0, 7));
            ticks_left = busy_ticks(it.op);
        end else begin
            plan.push_back(OP_START);
            plan.push_back(OP_WRITE);
            plan.push_back(OP_WAIT_ACK);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 1) != 0) begin
                    plan.push_back(OP_READ);
                end else begin
                    plan.push_back(OP_WRITE);
                    plan.push_back(OP_WAIT_ACK);
                end
            end
            plan.push_back(OP_STOP);
            if ($urandom_range(0, 7) == 0) plan.delete($urandom_range(0, plan.size() - 1));
            if ($urandom_range(0, 5) == 0) plan.push_back(OP_IDLE);
            it.op      = plan.pop_front();
            ticks_left = busy_ticks(it.op);
        end
    endtask

    task automatic run_stage(input int n_ticks, input int idle_pct);
        t_in_item it;
        int       sent;
        push_idle_pct = idle_pct;
        pop_idle_pct  = idle_pct;
        sent = 0;
        // finish the running transaction so the next slot-length write finds the bus idle
        while (sent < n_ticks || plan.size() != 0 || ticks_left != 0) begin
            make_tick(it);
            send_tick(it);
            sent++;
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_idle_pct = 5;
        pop_idle_pct  = 5;
        run_cmd(OP_IDLE, 8'h00, 1'b0, 1'b1);
        drain();
        write_phase(8'd1);
        send_op(OP_UNUSED, 8'hFF, 1'b1, 1'b1);
        send_op(OP_START, 8'h00, 1'b0, 1'b1);
        send_op(OP_STOP, 8'h00, 1'b0, 1'b1);
        repeat (busy_ticks(OP_START) - 1) send_op(OP_NONE, 8'h00, 1'b0, 1'b0);
        run_cmd(OP_WRITE, 8'hFF, 1'b0, 1'b0);
        run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 1'b1);
        run_cmd(OP_READ, 8'h00, 1'b1, 1'b1);
        run_cmd(OP_WAIT_ACK, 8'hFF, 1'b1, 1'b0);
        run_cmd(OP_READ, 8'hFF, 1'b0, 1'b0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 1'b0);
        drain();

        write_phase(8'd0);
        run_stage(80, 10);
        write_phase(8'($urandom_range(2, 6)));
        run_stage(50, 15);
        write_phase(8'd255);
        run_cmd(OP_STOP, 8'h00, 1'b0, 1'b1);
        drain();
        write_phase(8'd3);
        run_stage(40, 5);
        write_phase(8'd1);
        run_stage(60, 10);
        run_stage(60, 0);

        if (fail_count == 0 && results_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
